[rtl/hsvrgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and constants for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	// input word: hue in 1/64 degree, saturation and value as 8-bit fractions
	typedef struct packed {
		logic [14:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
	} hsv_word_t;

	// result word
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_word_t;

	typedef enum logic [2:0] {
		SECT_0 = 3'd0,
		SECT_1 = 3'd1,
		SECT_2 = 3'd2,
		SECT_3 = 3'd3,
		SECT_4 = 3'd4,
		SECT_5 = 3'd5
	} sector_t;

	// classified word passed from front to back
	typedef struct packed {
		sector_t    sector;
		logic [7:0] frac;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} cls_word_t;

	localparam int CLS_W = $bits(cls_word_t);

	localparam logic [14:0] HUE_TURN    = 15'd23040;
	localparam logic [11:0] SECTOR_SPAN = 12'd3840;
	// hue bits above [7:0] per sector: 3840 / 256
	localparam logic [6:0]  SECTOR_HI   = 7'd15;
	// floor(rem / 15) for rem < 3840 as (rem * 4370) >> 16
	localparam logic [12:0] DIV15_RECIP = 13'd4370;
	// floor(x / 255) for x <= 65152 as (x * 32897) >> 23
	localparam logic [15:0] DIV255_RECIP = 16'd32897;
	localparam logic [7:0]  FULL_SCALE  = 8'd255;
	localparam logic [8:0]  FRAC_SCALE  = 9'd256;
	localparam logic [16:0] DEN_QT      = 17'd65280;
	localparam logic [15:0] HALF_DEN_QT = 16'd32640;
	localparam logic [6:0]  HALF_DEN_P  = 7'd127;

endpackage

[rtl/hsvrgb_front.sv]
// ----------------------------------------------------------------------------
// hsvrgb_front
// Takes in HSV words, maps a hue at or above a full turn to zero, and splits it into sector and fraction.
// ----------------------------------------------------------------------------
module hsvrgb_front (
	input  logic                  start,
	input  logic                  full,
	input  hsvrgb_pkg::hsv_word_t hsv,
	output logic                  busy,
	output logic                  push,
	output hsvrgb_pkg::cls_word_t cls
);

	logic [14:0] hue_w;
	logic [6:0]  hue_hi;
	logic [2:0]  sect;
	logic [14:0] sect_base;
	logic [14:0] rem_w;
	logic [24:0] frac_prod;

	assign busy = full;
	assign push = start && !full;

	always_comb begin
		hue_w  = (hsv.hue >= hsvrgb_pkg::HUE_TURN) ? 15'd0 : hsv.hue;
		hue_hi = hue_w[14:8];
		// sector boundaries fall on multiples of 15 in the upper hue bits
		if (hue_hi < hsvrgb_pkg::SECTOR_HI) begin
			sect = 3'd0;
		end else if (hue_hi < 7'(2 * hsvrgb_pkg::SECTOR_HI)) begin
			sect = 3'd1;
		end else if (hue_hi < 7'(3 * hsvrgb_pkg::SECTOR_HI)) begin
			sect = 3'd2;
		end else if (hue_hi < 7'(4 * hsvrgb_pkg::SECTOR_HI)) begin
			sect = 3'd3;
		end else if (hue_hi < 7'(5 * hsvrgb_pkg::SECTOR_HI)) begin
			sect = 3'd4;
		end else begin
			sect = 3'd5;
		end
		sect_base = 15'(sect) * 15'(hsvrgb_pkg::SECTOR_SPAN);
		rem_w     = hue_w - sect_base;
		frac_prod = rem_w[11:0] * hsvrgb_pkg::DIV15_RECIP;
	end

	always_comb begin
		cls.sector     = hsvrgb_pkg::sector_t'(sect);
		cls.frac       = frac_prod[23:16];
		cls.saturation = hsv.saturation;
		cls.brightness = hsv.brightness;
	end

endmodule

[rtl/hsvrgb_queue.sv]
// ----------------------------------------------------------------------------
// hsvrgb_queue
// Small FIFO between the classify front and the arithmetic back.
// ----------------------------------------------------------------------------
module hsvrgb_queue #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  hsvrgb_pkg::cls_word_t wr_word,
	input  logic                  pop,
	output hsvrgb_pkg::cls_word_t rd_word,
	output logic                  empty,
	output logic                  full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	hsvrgb_pkg::cls_word_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == DEPTH_CNT);
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue write while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
`endif

endmodule

[rtl/hsvrgb_back.sv]
// ----------------------------------------------------------------------------
// hsvrgb_back
// Three-stage arithmetic pipe: products, rounding numerators, divide by 255
// and channel ordering by sector.
// ----------------------------------------------------------------------------
module hsvrgb_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  hsvrgb_pkg::cls_word_t cls,
	output logic                  strobe,
	output hsvrgb_pkg::rgb_word_t rgb
);

	// stage 1: products on s and v
	logic                 valid_s1;
	hsvrgb_pkg::sector_t  sector_s1;
	logic [7:0]           v_s1;
	logic [15:0]          sf_s1;
	logic [15:0]          st_s1;
	logic [15:0]          pp_s1;

	// stage 2: rounded numerators, already scaled down by 256 for q and t
	logic                 valid_s2;
	hsvrgb_pkg::sector_t  sector_s2;
	logic [7:0]           v_s2;
	logic [16:0]          nq_s2;
	logic [16:0]          nt_s2;
	logic [16:0]          np_s2;

	// stage 3: output register
	logic                 valid_s3;
	logic [7:0]           v_s3;
	hsvrgb_pkg::rgb_word_t rgb_s3;

	logic [16:0] st_full;
	logic [8:0]  frac_inv;
	logic [23:0] mq;
	logic [23:0] mt;
	logic [24:0] rq;
	logic [24:0] rt;
	logic [32:0] dq;
	logic [32:0] dt;
	logic [32:0] dp;
	logic [7:0]  p_val;
	logic [7:0]  q_val;
	logic [7:0]  t_val;
	hsvrgb_pkg::rgb_word_t rgb_sel;

	always_comb begin
		frac_inv = hsvrgb_pkg::FRAC_SCALE - {1'b0, cls.frac};
		st_full  = cls.saturation * frac_inv;
	end

	always_ff @(posedge clk) begin
		sector_s1 <= cls.sector;
		v_s1      <= cls.brightness;
		sf_s1     <= cls.saturation * cls.frac;
		st_s1     <= st_full[15:0];
		pp_s1     <= cls.brightness * (hsvrgb_pkg::FULL_SCALE - cls.saturation);
	end

	always_comb begin
		mq = v_s1 * (hsvrgb_pkg::DEN_QT - {1'b0, sf_s1});
		mt = v_s1 * (hsvrgb_pkg::DEN_QT - {1'b0, st_s1});
		rq = {1'b0, mq} + 25'(hsvrgb_pkg::HALF_DEN_QT);
		rt = {1'b0, mt} + 25'(hsvrgb_pkg::HALF_DEN_QT);
	end

	always_ff @(posedge clk) begin
		sector_s2 <= sector_s1;
		v_s2      <= v_s1;
		nq_s2     <= rq[24:8];
		nt_s2     <= rt[24:8];
		np_s2     <= {1'b0, pp_s1} + 17'(hsvrgb_pkg::HALF_DEN_P);
	end

	always_comb begin
		dq    = nq_s2 * hsvrgb_pkg::DIV255_RECIP;
		dt    = nt_s2 * hsvrgb_pkg::DIV255_RECIP;
		dp    = np_s2 * hsvrgb_pkg::DIV255_RECIP;
		q_val = dq[30:23];
		t_val = dt[30:23];
		p_val = dp[30:23];
	end

	always_comb begin
		case (sector_s2)
			hsvrgb_pkg::SECT_0: rgb_sel = '{red: v_s2,  green: t_val, blue: p_val};
			hsvrgb_pkg::SECT_1: rgb_sel = '{red: q_val, green: v_s2,  blue: p_val};
			hsvrgb_pkg::SECT_2: rgb_sel = '{red: p_val, green: v_s2,  blue: t_val};
			hsvrgb_pkg::SECT_3: rgb_sel = '{red: p_val, green: q_val, blue: v_s2};
			hsvrgb_pkg::SECT_4: rgb_sel = '{red: t_val, green: p_val, blue: v_s2};
			default:            rgb_sel = '{red: v_s2,  green: p_val, blue: q_val};
		endcase
	end

	always_ff @(posedge clk) begin
		rgb_s3 <= rgb_sel;
		v_s3   <= v_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign strobe = valid_s3;
	assign rgb    = rgb_s3;

`ifndef NO_ASSERTIONS
	// every component is scaled down from v
	a_within_value: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (rgb_s3.red <= v_s3) && (rgb_s3.green <= v_s3) && (rgb_s3.blue <= v_s3))
		else $error("rgb component above value");
	// one channel always carries v itself
	a_has_value: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (rgb_s3.red == v_s3) || (rgb_s3.green == v_s3) || (rgb_s3.blue == v_s3))
		else $error("no rgb component equals value");
`endif

endmodule

[rtl/hsv_to_rgb_convert.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert
// HSV to RGB converter: classify front, small queue, pipelined arithmetic back.
// ----------------------------------------------------------------------------
//  channel   ports               handshake
//  input     start, busy, hsv    taken when start is high and busy is low
//  output    strobe, rgb         rgb valid for the one cycle strobe is high
//
// one word per clock while busy is low; the hsv word that is taken passes the
// queue and then the stage 1 and stage 2 registers of the back, and strobe and
// the rgb word come from the output register.
// the back pops the queue whenever it is not empty, so busy stays low in normal use.
// reset empties the queue and clears the pipe valids; no clearing pass.
// the receiver cannot stall: each result is presented exactly once.
module hsv_to_rgb_convert #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  hsvrgb_pkg::hsv_word_t hsv,
	output logic                  strobe,
	output hsvrgb_pkg::rgb_word_t rgb
);

	logic                  push;
	logic                  q_full;
	logic                  q_empty;
	logic                  pop;
	hsvrgb_pkg::cls_word_t cls_in;
	hsvrgb_pkg::cls_word_t cls_out;

	hsvrgb_front u_front (
		.start (start),
		.full  (q_full),
		.hsv   (hsv),
		.busy  (busy),
		.push  (push),
		.cls   (cls_in)
	);

	hsvrgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_word (cls_in),
		.pop     (pop),
		.rd_word (cls_out),
		.empty   (q_empty),
		.full    (q_full)
	);

	// the pipe never stalls, so any queued word moves on at once
	assign pop = !q_empty;

	hsvrgb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pop),
		.cls      (cls_out),
		.strobe   (strobe),
		.rgb      (rgb)
	);

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy, 4))
		else $error("result without a word taken four cycles earlier");
`endif

endmodule
